// ===== hw/rtl/scale2x_pixel_upscaler_macros.svh =====
// Assertion macros for the scale2x pixel upscaler.
// No dependencies; included by the modules that carry checks.
`ifndef SCALE2X_PIXEL_UPSCALER_MACROS_SVH
`define SCALE2X_PIXEL_UPSCALER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define S2X_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scale2x: implication check failed");
// Next-cycle implication.
`define S2X_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scale2x: next-cycle check failed");
`else
`define S2X_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define S2X_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/s2x_pkg.sv =====
// Shared types, constants and the scale2x selection rule.
// No dependencies; used by every module of the upscaler but the line store.
`timescale 1ns / 1ps
`default_nettype none
package s2x_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int PIXEL_BITS      = 32;
   localparam int COL_BITS        = $clog2(MAX_WIDTH);
   localparam int ROW_BITS        = 16;
   localparam int WIDTH_REG_BITS  = 13;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int BANK_BITS       = 2;
   localparam int Q_DEPTH         = 4;
   localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
   localparam int Q_LEVEL_BITS    = $clog2(Q_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd64;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd64;

   localparam logic [BANK_BITS-1:0] BANK_0 = 2'd0;
   localparam logic [BANK_BITS-1:0] BANK_1 = 2'd1;
   localparam logic [BANK_BITS-1:0] BANK_2 = 2'd2;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic      op;
      pixel_type color;
   } req_word_type;

   typedef struct packed {
      pixel_type             top_left;
      pixel_type             top_right;
      pixel_type             bottom_left;
      pixel_type             bottom_right;
      logic [COL_BITS-1:0]   block_column;
      logic [ROW_BITS-1:0]   block_row;
      logic                  frame_done;
   } rsp_word_type;

   // One classified item on its way from the front to the back.
   typedef struct packed {
      logic                is_flush;
      logic                emit1;     // block left of this column (or the flush block)
      logic                emit2;     // block at this column, row end only
      logic                top_ok;    // row above exists
      logic                left1_ok;
      logic                left2_ok;
      logic                right_ok;  // flush: right neighbour exists
      logic                done;
      logic [COL_BITS-1:0] col;
      logic [ROW_BITS-1:0] row;
      pixel_type           color;
      pixel_type           ou_a;      // one row up, flush column
      pixel_type           ou_b;      // one row up, this column / flush column + 1
      pixel_type           tu;        // two rows up, this column / flush column
   } queue_entry_type;

   typedef struct packed {
      logic [Q_LEVEL_BITS-1:0] level;
      logic                    not_empty;
   } queue_status_type;

   typedef struct packed {
      pixel_type tl;
      pixel_type tr;
      pixel_type bl;
      pixel_type br;
   } quad_type;

   // Previous bank in rotation order (mod 3).
   function automatic logic [BANK_BITS-1:0] bank_prev(input logic [BANK_BITS-1:0] b);
      logic [BANK_BITS-1:0] r;
      unique case (b)
         BANK_0:  r = BANK_2;
         BANK_1:  r = BANK_0;
         default: r = BANK_1;
      endcase
      return r;
   endfunction

   // Next bank in rotation order (mod 3).
   function automatic logic [BANK_BITS-1:0] bank_next(input logic [BANK_BITS-1:0] b);
      logic [BANK_BITS-1:0] r;
      unique case (b)
         BANK_0:  r = BANK_1;
         BANK_1:  r = BANK_2;
         default: r = BANK_0;
      endcase
      return r;
   endfunction

   // Scale2x selection: a above, b right, c left, d below centre p.
   function automatic quad_type scale2x_rule(input pixel_type p, input pixel_type a,
                                             input pixel_type b, input pixel_type c,
                                             input pixel_type d);
      quad_type q;
      q.tl = (c == a && c != d && a != b) ? a : p;
      q.tr = (a == b && a != c && b != d) ? b : p;
      q.bl = (d == c && d != b && c != a) ? c : p;
      q.br = (b == d && b != a && d != c) ? d : p;
      return q;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/scale2x_pixel_upscaler.sv =====
// Top level of the scale2x pixel-art upscaler: front end, queue, back end.
// Depends on s2x_pkg, s2x_front, s2x_queue and s2x_back.
//
//   port group  direction  handshake             payload
//   req_        in         req_valid/req_stall   s2x_pkg::req_word_type (op, color)
//   rsp_        out        rsp_valid/rsp_stall   s2x_pkg::rsp_word_type (2x2 block)
//   csr_        in         csr_write_en          csr_index, csr_wdata
//
// Flow: one word a clock in while req_stall is low; the back end takes one word
// a clock unless rsp_stall holds it, a row-closing pixel's two blocks in turn.
// Path: front-end stage register, queue, result register that drives rsp_valid.
// Reset: synchronous; no clearing pass, line stores are read only after write.
// Stalls: the queue absorbs result-side stalls; req_stall rises once the queue
// and the word in flight fill it.
`timescale 1ns / 1ps
`default_nettype none
module scale2x_pixel_upscaler (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [s2x_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [s2x_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire s2x_pkg::req_word_type               req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output s2x_pkg::rsp_word_type                    rsp_word
);

   logic                       push_valid;
   s2x_pkg::queue_entry_type   push_entry;
   logic                       pop;
   s2x_pkg::queue_entry_type   head_entry;
   s2x_pkg::queue_status_type  q_stat;

   // Classify words, keep the raster position and drive the line stores.
   s2x_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .q_stat       (q_stat),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   // Decouple the two halves so each can stall on its own.
   s2x_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   // Build the neighbour window and emit the 2x2 blocks.
   s2x_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/s2x_line_ram.sv =====
// Generic line store: one write port, two registered read ports.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module s2x_line_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic      [WIDTH-1:0]         rd_a_data,
   output logic      [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_a_addr];
      rd_b_ff <= store_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/s2x_front.sv =====
// Front end: configuration, raster position, line store writes and reads,
// and classification of each word. Depends on s2x_pkg and s2x_line_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "scale2x_pixel_upscaler_macros.svh"
module s2x_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_en,
   input  wire logic [s2x_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [s2x_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire s2x_pkg::req_word_type                 req_word,
   input  wire s2x_pkg::queue_status_type             q_stat,
   output logic                                       push_valid,
   output s2x_pkg::queue_entry_type                   push_entry
);

   logic [s2x_pkg::WIDTH_REG_BITS-1:0]  width_ff;
   logic [s2x_pkg::HEIGHT_REG_BITS-1:0] height_ff;
   logic [s2x_pkg::COL_BITS-1:0]        col_ff,  col_in;
   logic [s2x_pkg::ROW_BITS-1:0]        row_ff,  row_in;
   logic [s2x_pkg::COL_BITS-1:0]        fcol_ff, fcol_in;
   logic [s2x_pkg::BANK_BITS-1:0]       bank_ff, bank_in;

   logic                                s1_valid_ff;
   s2x_pkg::queue_entry_type            s1_entry_ff, s1_entry_in;
   logic [s2x_pkg::BANK_BITS-1:0]       s1_one_ff, s1_two_ff;

   logic [s2x_pkg::WIDTH_REG_BITS-1:0]  eff_w;
   logic [s2x_pkg::COL_BITS-1:0]        w_last;
   logic [s2x_pkg::HEIGHT_REG_BITS-1:0] eff_h;
   logic                                accept, is_flush, frame_full;
   logic                                pix_take, flush_take, row_end, flush_end;
   logic [s2x_pkg::BANK_BITS-1:0]       one_bank, two_bank;
   logic [s2x_pkg::COL_BITS-1:0]        one_addr_a, one_addr_b, two_addr;
   logic [s2x_pkg::Q_LEVEL_BITS-1:0]    pending;

   s2x_pkg::pixel_type rd_a [3];
   s2x_pkg::pixel_type rd_b [3];

   // Clamp the width register to the range the line stores support; a zero height counts as one.
   always_comb begin
      priority if (width_ff == '0) begin
         eff_w = s2x_pkg::WIDTH_REG_BITS'(1);
      end else if (width_ff > s2x_pkg::WIDTH_REG_BITS'(s2x_pkg::MAX_WIDTH)) begin
         eff_w = s2x_pkg::WIDTH_REG_BITS'(s2x_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
   end

   assign w_last = s2x_pkg::COL_BITS'(eff_w - s2x_pkg::WIDTH_REG_BITS'(1));
   assign eff_h  = (height_ff == '0) ? s2x_pkg::HEIGHT_REG_BITS'(1) : height_ff;

   // Hold input while the queue could not take this word and the one in flight.
   assign pending    = q_stat.level + s2x_pkg::Q_LEVEL_BITS'(s1_valid_ff);
   assign req_stall  = pending >= s2x_pkg::Q_LEVEL_BITS'(s2x_pkg::Q_DEPTH);
   assign accept     = req_valid && !req_stall;
   assign is_flush   = req_word.op == s2x_pkg::OP_FLUSH;
   assign frame_full = row_ff >= eff_h;
   assign pix_take   = accept && !is_flush && !frame_full;
   assign flush_take = accept && is_flush && frame_full;
   assign row_end    = col_ff == w_last;
   assign flush_end  = fcol_ff == w_last;

   assign one_bank = s2x_pkg::bank_prev(bank_ff);
   assign two_bank = s2x_pkg::bank_prev(one_bank);

   assign one_addr_a = fcol_ff;
   assign one_addr_b = is_flush ? fcol_ff + s2x_pkg::COL_BITS'(1) : col_ff;
   assign two_addr   = is_flush ? fcol_ff : col_ff;

   for (genvar i = 0; i < 3; i++) begin : g_bank
      s2x_line_ram #(
         .DEPTH (s2x_pkg::MAX_WIDTH),
         .WIDTH (s2x_pkg::PIXEL_BITS)
      ) u_ram (
         .clock     (clock),
         .wr_en     (pix_take && bank_ff == s2x_pkg::BANK_BITS'(i)),
         .wr_addr   (col_ff),
         .wr_data   (req_word.color),
         .rd_a_addr ((one_bank == s2x_pkg::BANK_BITS'(i)) ? one_addr_a : two_addr),
         .rd_b_addr (one_addr_b),
         .rd_a_data (rd_a[i]),
         .rd_b_data (rd_b[i])
      );
   end

   // Position counters and bank rotation.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fcol_in = fcol_ff;
      bank_in = bank_ff;
      priority if (csr_write_en) begin
         col_in  = '0;
         row_in  = '0;
         fcol_in = '0;
      end else if (pix_take) begin
         if (row_end) begin
            col_in  = '0;
            row_in  = row_ff + s2x_pkg::ROW_BITS'(1);
            bank_in = s2x_pkg::bank_next(bank_ff);
         end else begin
            col_in = col_ff + s2x_pkg::COL_BITS'(1);
         end
      end else if (flush_take) begin
         if (flush_end) begin
            col_in  = '0;
            row_in  = '0;
            fcol_in = '0;
         end else begin
            fcol_in = fcol_ff + s2x_pkg::COL_BITS'(1);
         end
      end
   end

   // Classify the word; data fields are filled from the registered line store reads.
   always_comb begin
      s1_entry_in          = '0;
      s1_entry_in.is_flush = is_flush;
      s1_entry_in.color    = req_word.color;
      if (is_flush) begin
         s1_entry_in.emit1    = 1'b1;
         s1_entry_in.top_ok   = eff_h > s2x_pkg::HEIGHT_REG_BITS'(1);
         s1_entry_in.left1_ok = fcol_ff != '0;
         s1_entry_in.right_ok = !flush_end;
         s1_entry_in.done     = flush_end;
         s1_entry_in.col      = fcol_ff;
         s1_entry_in.row      = s2x_pkg::ROW_BITS'(eff_h - s2x_pkg::HEIGHT_REG_BITS'(1));
      end else begin
         s1_entry_in.emit1    = row_ff != '0 && col_ff != '0;
         s1_entry_in.emit2    = row_ff != '0 && row_end;
         s1_entry_in.top_ok   = row_ff > s2x_pkg::ROW_BITS'(1);
         s1_entry_in.left1_ok = col_ff > s2x_pkg::COL_BITS'(1);
         s1_entry_in.left2_ok = col_ff != '0;
         s1_entry_in.col      = col_ff;
         s1_entry_in.row      = row_ff - s2x_pkg::ROW_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= s2x_pkg::WIDTH_RESET;
         height_ff   <= s2x_pkg::HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         fcol_ff     <= '0;
         bank_ff     <= s2x_pkg::BANK_0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               s2x_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[s2x_pkg::WIDTH_REG_BITS-1:0];
               s2x_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         fcol_ff     <= fcol_in;
         bank_ff     <= bank_in;
         s1_valid_ff <= pix_take || flush_take;
      end
   end

   always_ff @(posedge clock) begin
      s1_entry_ff <= s1_entry_in;
      s1_one_ff   <= one_bank;
      s1_two_ff   <= two_bank;
   end

   // Steer the registered read data by the roles the banks had at read time.
   always_comb begin
      push_entry = s1_entry_ff;
      unique case (s1_one_ff)
         s2x_pkg::BANK_0: begin push_entry.ou_a = rd_a[0]; push_entry.ou_b = rd_b[0]; end
         s2x_pkg::BANK_1: begin push_entry.ou_a = rd_a[1]; push_entry.ou_b = rd_b[1]; end
         default:         begin push_entry.ou_a = rd_a[2]; push_entry.ou_b = rd_b[2]; end
      endcase
      unique case (s1_two_ff)
         s2x_pkg::BANK_0: push_entry.tu = rd_a[0];
         s2x_pkg::BANK_1: push_entry.tu = rd_a[1];
         default:         push_entry.tu = rd_a[2];
      endcase
   end

   assign push_valid = s1_valid_ff;

   `S2X_ASSERT_NEXT(a_frame_restart, clock, reset, flush_take && flush_end,
                    row_ff == '0 && col_ff == '0 && fcol_ff == '0)
   `S2X_ASSERT_IMPLY(a_roles_distinct, clock, reset, 1'b1,
                     bank_ff != one_bank && bank_ff != two_bank && one_bank != two_bank)

endmodule
`default_nettype wire

// ===== hw/rtl/s2x_queue.sv =====
// Short queue of classified words between the front and the back end.
// Depends on s2x_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "scale2x_pixel_upscaler_macros.svh"
module s2x_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire s2x_pkg::queue_entry_type   push_entry,
   input  wire logic                       pop,
   output s2x_pkg::queue_entry_type        head_entry,
   output s2x_pkg::queue_status_type       q_stat
);

   s2x_pkg::queue_entry_type          store_ff [s2x_pkg::Q_DEPTH];
   logic [s2x_pkg::Q_PTR_BITS-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [s2x_pkg::Q_LEVEL_BITS-1:0]  level_ff, level_in;

   always_comb begin
      level_in = level_ff;
      unique case ({push_valid, pop})
         2'b10:   level_in = level_ff + s2x_pkg::Q_LEVEL_BITS'(1);
         2'b01:   level_in = level_ff - s2x_pkg::Q_LEVEL_BITS'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + s2x_pkg::Q_PTR_BITS'(1);
         if (pop)        rd_ptr_ff <= rd_ptr_ff + s2x_pkg::Q_PTR_BITS'(1);
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry       = store_ff[rd_ptr_ff];
   assign q_stat.level     = level_ff;
   assign q_stat.not_empty = level_ff != '0;

   `S2X_ASSERT_IMPLY(a_no_overflow, clock, reset, push_valid && !pop,
                     level_ff != s2x_pkg::Q_LEVEL_BITS'(s2x_pkg::Q_DEPTH))
   `S2X_ASSERT_IMPLY(a_no_underflow, clock, reset, pop, level_ff != '0)

endmodule
`default_nettype wire

// ===== hw/rtl/s2x_back.sv =====
// Back end: neighbour window, scale2x selection and the result register.
// Depends on s2x_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "scale2x_pixel_upscaler_macros.svh"
module s2x_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire s2x_pkg::queue_status_type  q_stat,
   input  wire s2x_pkg::queue_entry_type   head_entry,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output s2x_pkg::rsp_word_type           rsp_word
);

   // One row up at columns c-1 and c-2, two rows up at c-1, current row at c-1.
   s2x_pkg::pixel_type    ou1_ff, ou2_ff, tu1_ff, cur1_ff;
   logic                  second_ff, second_in;
   logic                  rsp_valid_ff;
   s2x_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  head_valid, two_part, want_emit, out_free, load;
   s2x_pkg::pixel_type    p_pix, a_pix, b_pix, c_pix, d_pix;
   logic [s2x_pkg::COL_BITS-1:0] blk_col;
   logic                  blk_done;
   s2x_pkg::quad_type     quad;

   assign head_valid = q_stat.not_empty;
   assign two_part   = head_entry.emit1 && head_entry.emit2;
   assign want_emit  = head_entry.is_flush || (head_entry.emit1 && !second_ff) ||
                       head_entry.emit2;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load       = head_valid && want_emit && out_free;
   assign pop        = head_valid &&
                       (!want_emit || (out_free && !(two_part && !second_ff)));

   always_comb begin
      second_in = second_ff;
      priority if (pop) begin
         second_in = 1'b0;
      end else if (load && two_part) begin
         second_in = 1'b1;
      end
   end

   // Pick the neighbours of the block on offer.
   always_comb begin
      priority if (head_entry.is_flush) begin
         p_pix    = head_entry.ou_a;
         a_pix    = head_entry.top_ok   ? head_entry.tu   : head_entry.ou_a;
         b_pix    = head_entry.right_ok ? head_entry.ou_b : head_entry.ou_a;
         c_pix    = head_entry.left1_ok ? ou1_ff          : head_entry.ou_a;
         d_pix    = head_entry.ou_a;
         blk_col  = head_entry.col;
         blk_done = head_entry.done;
      end else if (head_entry.emit1 && !second_ff) begin
         p_pix    = ou1_ff;
         a_pix    = head_entry.top_ok   ? tu1_ff : ou1_ff;
         b_pix    = head_entry.ou_b;
         c_pix    = head_entry.left1_ok ? ou2_ff : ou1_ff;
         d_pix    = cur1_ff;
         blk_col  = head_entry.col - s2x_pkg::COL_BITS'(1);
         blk_done = 1'b0;
      end else begin
         p_pix    = head_entry.ou_b;
         a_pix    = head_entry.top_ok   ? head_entry.tu : head_entry.ou_b;
         b_pix    = head_entry.ou_b;
         c_pix    = head_entry.left2_ok ? ou1_ff        : head_entry.ou_b;
         d_pix    = head_entry.color;
         blk_col  = head_entry.col;
         blk_done = 1'b0;
      end
   end

   assign quad = s2x_pkg::scale2x_rule(p_pix, a_pix, b_pix, c_pix, d_pix);

   always_comb begin
      rsp_word_in.top_left     = quad.tl;
      rsp_word_in.top_right    = quad.tr;
      rsp_word_in.bottom_left  = quad.bl;
      rsp_word_in.bottom_right = quad.br;
      rsp_word_in.block_column = blk_col;
      rsp_word_in.block_row    = head_entry.row;
      rsp_word_in.frame_done   = blk_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         second_ff <= second_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= rsp_word_in;
      end
      // Advance the window when a word leaves the queue.
      if (pop) begin
         if (head_entry.is_flush) begin
            ou1_ff <= head_entry.ou_a;
         end else begin
            ou2_ff  <= ou1_ff;
            ou1_ff  <= head_entry.ou_b;
            tu1_ff  <= head_entry.tu;
            cur1_ff <= head_entry.color;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `S2X_ASSERT_IMPLY(a_second_half, clock, reset, second_ff,
                     head_valid && two_part && !head_entry.is_flush)

endmodule
`default_nettype wire
